[rtl/core/sha256_pkg.sv]
package sha256_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned Rounds = 64;
  localparam int unsigned RndW   = $clog2(Rounds);

  // Round constants
  localparam logic [WordW-1:0] ROUND_K [Rounds] = '{
    32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
    32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
    32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
    32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
    32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
    32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
    32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
    32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
    32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
    32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
    32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
    32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
    32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
    32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
    32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
    32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
  };

  // Initial hash values H0..H7
  localparam logic [WordW-1:0] H_INIT [8] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
  };

  localparam logic [7:0] PAD_BYTE   = 8'h80;
  localparam logic [5:0] LEN_POS    = 6'd56;
  localparam logic [5:0] LAST_POS   = 6'd63;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FOLD,
    ST_PAD,
    ST_EMIT
  } state_e;

  // Control toward the message schedule
  typedef struct packed {
    logic       load;
    logic       step;
    logic [7:0] data;
  } sched_ctl_t;

  // Control toward the round unit
  typedef struct packed {
    logic start;
    logic step;
    logic fold;
    logic shift;
    logic init;
  } round_ctl_t;

  function automatic logic [WordW-1:0] ror(input logic [WordW-1:0] x, input int unsigned n);
    ror = (x >> n) | (x << (WordW - n));
  endfunction

  function automatic logic [WordW-1:0] big_sigma0(input logic [WordW-1:0] x);
    big_sigma0 = ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
  endfunction

  function automatic logic [WordW-1:0] big_sigma1(input logic [WordW-1:0] x);
    big_sigma1 = ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
  endfunction

  function automatic logic [WordW-1:0] small_sigma0(input logic [WordW-1:0] x);
    small_sigma0 = ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [WordW-1:0] small_sigma1(input logic [WordW-1:0] x);
    small_sigma1 = ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
  endfunction

endpackage

[rtl/core/sha256_sched.sv]
module sha256_sched
  import sha256_pkg::*;
(
  input  logic             clk_i,
  input  sched_ctl_t       ctl_i,
  output logic [WordW-1:0] wt_o
);

  localparam int unsigned BufW = 16 * WordW;

  logic [BufW-1:0]  buf_q;
  logic [WordW-1:0] w0, w1, w9, w14, w_new;

  // Tap the sixteen-word window, word 0 in the top bits
  assign w0  = buf_q[BufW-1 -: WordW];
  assign w1  = buf_q[BufW-1-WordW -: WordW];
  assign w9  = buf_q[BufW-1-9*WordW -: WordW];
  assign w14 = buf_q[BufW-1-14*WordW -: WordW];

  assign w_new = small_sigma1(w14) + w9 + small_sigma0(w1) + w0;
  assign wt_o  = w0;

  // Shift in bytes while collecting, words while scheduling
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      buf_q <= {buf_q[BufW-9:0], ctl_i.data};
    end else if (ctl_i.step) begin
      buf_q <= {buf_q[BufW-WordW-1:0], w_new};
    end
  end

endmodule

[rtl/core/sha256_round.sv]
module sha256_round
  import sha256_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  round_ctl_t       ctl_i,
  input  logic [RndW-1:0]  rnd_i,
  input  logic [WordW-1:0] wt_i,
  output logic [WordW-1:0] digest_o
);

  logic [WordW-1:0] chain_q [8];
  logic [WordW-1:0] v_q [8];
  logic [WordW-1:0] t1, t2, ch, maj;

  // One round of the compression on the working variables
  assign ch  = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
  assign maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
  assign t1  = v_q[7] + big_sigma1(v_q[4]) + ch + ROUND_K[rnd_i] + wt_i;
  assign t2  = big_sigma0(v_q[0]) + maj;

  assign digest_o = chain_q[0];

  // Load, advance the working variables
  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      for (int i = 0; i < 8; i++) v_q[i] <= chain_q[i];
    end else if (ctl_i.step) begin
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end
  end

  // Fold the block result into the chain, rotate it out, restart it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) chain_q[i] <= H_INIT[i];
    end else if (ctl_i.init) begin
      for (int i = 0; i < 8; i++) chain_q[i] <= H_INIT[i];
    end else if (ctl_i.fold) begin
      for (int i = 0; i < 8; i++) chain_q[i] <= chain_q[i] + v_q[i];
    end else if (ctl_i.shift) begin
      for (int i = 0; i < 7; i++) chain_q[i] <= chain_q[i+1];
      chain_q[7] <= chain_q[0];
    end
  end

endmodule

[rtl/core/sha256_message_hasher.sv]
// SHA-256 message hasher.
// Input channel (s_axis): one message byte per request in tdata, tuser set when
// the byte belongs to the message, tlast on the final request. A final request
// with tuser low ends the message without a byte (empty message allowed).
// Output channel (m_axis): the eight digest words H0..H7 in order, word index
// in tuser, tlast on the eighth word.
// Timing: bytes are accepted back to back; the 64th byte of a block starts the
// shared round unit, which runs one round per cycle and then folds the block
// into the chain value, with s_axis_tready_o low meanwhile. On the final
// request the padding bytes are shifted in at one per cycle up to the end of
// the block; a marker past byte 55 takes a second block of 64 padding bytes.
// The eight digest words go out one per accepted cycle. s_axis_tready_o stays
// low from the final request until the last digest word is taken.
// Reset returns the chain value to the initial hash values and the byte
// count to zero; no clearing pass is needed. A stalled receiver holds the
// current digest word on m_axis until it is taken.
module sha256_message_hasher
  import sha256_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tuser_i,   // [0] has_byte
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [31:0] digest_word
  output logic [2:0]  m_axis_tuser_o,   // [2:0] word_index
  output logic        m_axis_tlast_o
);

  state_e          state_q, state_d, ret_q, ret_d;
  logic [RndW-1:0] rnd_q, rnd_d;
  logic [5:0]      pos_q, pos_d;
  logic [63:0]     cnt_q, cnt_d;
  logic            sent_q, sent_d;
  logic            lenblk_q, lenblk_d;
  logic [2:0]      idx_q, idx_d;
  logic [63:0]     bits;
  logic [2:0]      len_sel;
  logic [7:0]      pad_data;
  sched_ctl_t      sctl;
  round_ctl_t      rctl;
  logic [WordW-1:0] wt;

  // Pick the next padding byte: marker, zero or length
  assign bits    = {cnt_q[60:0], 3'b000};
  assign len_sel = 3'd7 - pos_q[2:0];
  always_comb begin
    if (!sent_q) begin
      pad_data = PAD_BYTE;
    end else if (lenblk_q && (pos_q >= LEN_POS)) begin
      pad_data = bits[{len_sel, 3'b000} +: 8];
    end else begin
      pad_data = 8'h00;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ret_q    <= ST_IDLE;
      rnd_q    <= '0;
      pos_q    <= '0;
      cnt_q    <= '0;
      sent_q   <= 1'b0;
      lenblk_q <= 1'b0;
      idx_q    <= '0;
    end else begin
      state_q  <= state_d;
      ret_q    <= ret_d;
      rnd_q    <= rnd_d;
      pos_q    <= pos_d;
      cnt_q    <= cnt_d;
      sent_q   <= sent_d;
      lenblk_q <= lenblk_d;
      idx_q    <= idx_d;
    end
  end

  // Sequence collection, rounds, padding and digest output
  always_comb begin
    state_d  = state_q;
    ret_d    = ret_q;
    rnd_d    = rnd_q;
    pos_d    = pos_q;
    cnt_d    = cnt_q;
    sent_d   = sent_q;
    lenblk_d = lenblk_q;
    idx_d    = idx_q;
    sctl     = '0;
    rctl     = '0;
    s_axis_tready_o = 1'b0;
    m_axis_tvalid_o = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          sent_d   = 1'b0;
          lenblk_d = 1'b0;
          if (s_axis_tuser_i) begin
            sctl.load = 1'b1;
            sctl.data = s_axis_tdata_i;
            cnt_d     = cnt_q + 64'd1;
            pos_d     = pos_q + 6'd1;
          end
          if (s_axis_tuser_i && (pos_q == LAST_POS)) begin
            rctl.start = 1'b1;
            rnd_d      = '0;
            state_d    = ST_ROUND;
            ret_d      = s_axis_tlast_i ? ST_PAD : ST_IDLE;
          end else if (s_axis_tlast_i) begin
            state_d = ST_PAD;
          end
        end
      end

      ST_ROUND: begin
        rctl.step = 1'b1;
        sctl.step = 1'b1;
        rnd_d     = rnd_q + RndW'(1);
        if (rnd_q == RndW'(Rounds - 1)) begin
          state_d = ST_FOLD;
        end
      end

      ST_FOLD: begin
        rctl.fold = 1'b1;
        state_d   = ret_q;
      end

      ST_PAD: begin
        sctl.load = 1'b1;
        sctl.data = pad_data;
        pos_d     = pos_q + 6'd1;
        if (!sent_q) begin
          sent_d = 1'b1;
          if (pos_q < LEN_POS) begin
            lenblk_d = 1'b1;
          end
        end
        if (pos_q == LAST_POS) begin
          rctl.start = 1'b1;
          rnd_d      = '0;
          state_d    = ST_ROUND;
          if (lenblk_q) begin
            ret_d = ST_EMIT;
          end else begin
            ret_d    = ST_PAD;
            lenblk_d = 1'b1;
          end
        end
      end

      ST_EMIT: begin
        m_axis_tvalid_o = 1'b1;
        if (m_axis_tready_i) begin
          rctl.shift = 1'b1;
          idx_d      = idx_q + 3'd1;
          if (idx_q == 3'd7) begin
            rctl.init = 1'b1;
            cnt_d     = '0;
            state_d   = ST_IDLE;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign m_axis_tuser_o = idx_q;
  assign m_axis_tlast_o = (idx_q == 3'd7);

  sha256_sched u_sched (
    .clk_i (clk_i),
    .ctl_i (sctl),
    .wt_o  (wt)
  );

  sha256_round u_round (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (rctl),
    .rnd_i    (rnd_q),
    .wt_i     (wt),
    .digest_o (m_axis_tdata_o)
  );

endmodule

[rtl/core/sha256_checker.sv]
module sha256_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        s_axis_tlast_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [31:0] m_axis_tdata_o,
  input logic [2:0]  m_axis_tuser_o,
  input logic        m_axis_tlast_o
);

  // Hold a stalled digest word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("stalled digest word changed");

  // Mark the eighth word only
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tlast_o == (m_axis_tuser_o == 3'd7)))
    else $error("tlast does not match word index");

  // Advance the word index through the digest without gaps
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o |=>
      m_axis_tvalid_o && (m_axis_tuser_o == 3'($past(m_axis_tuser_o) + 3'd1)))
    else $error("digest words not consecutive");

  // Block new requests while the digest is out
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !s_axis_tready_o)
    else $error("input ready during digest output");

  // Drop ready after a final request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i |=> !s_axis_tready_o)
    else $error("input ready right after final request");

endmodule

bind sha256_message_hasher sha256_checker u_checker (.*);
